@@ design/gwm_pkg.sv @@
// Shared types, constants and the star-closure function for the glob wildcard matcher.
// No dependencies; gwm_in_if, gwm_step and the core use this package.
package gwm_pkg;

    localparam int MAX_PATTERN  = 32;
    localparam int POS_N        = MAX_PATTERN + 1;
    localparam int LEN_W        = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CLOSE_LEVELS = (POS_N > 1) ? $clog2(POS_N) : 1;
    localparam int OP_W         = 2;
    localparam int CHAR_W       = 8;

    localparam logic [CHAR_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_BYTE  = 8'h3F;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } gwm_op_t;

    typedef logic [POS_N-1:0]       pos_vec_t;
    typedef logic [MAX_PATTERN-1:0] star_vec_t;
    typedef logic [CHAR_W-1:0]      char_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        star_vec_t        star;
        pos_vec_t         active;
        logic             overflow;
    } gwm_state_t;

    typedef struct packed {
        logic             emit;
        logic             matched;
        logic             overflow;
        logic             store_we;
        logic [IDX_W-1:0] store_idx;
    } gwm_ctrl_t;

    // Carry each active position forward across runs of stars:
    // c[i] = seed[i] | (c[i-1] & star[i-1]), as a log-depth prefix network.
    function automatic pos_vec_t gwm_close(input pos_vec_t seed, input star_vec_t star);
        pos_vec_t g;
        pos_vec_t p;
        g = seed;
        p = {star, 1'b0};
        for (int l = 0; l < CLOSE_LEVELS; l++) begin
            g = g | (p & (g << (1 << l)));
            p = p & (p << (1 << l));
        end
        return g;
    endfunction

endpackage

@@ design/gwm_in_if.sv @@
// Input channel: valid/ready handshake carrying one opcode and one byte.
// Depends on gwm_pkg for field widths.
interface gwm_in_if;
    logic                        valid;
    logic                        ready;
    logic [gwm_pkg::OP_W-1:0]    opcode;
    logic [gwm_pkg::CHAR_W-1:0]  char_value;

    modport source (output valid, output opcode, output char_value, input ready);
    modport sink   (input valid, input opcode, input char_value, output ready);
endinterface

@@ design/gwm_out_if.sv @@
// Result channel: valid/ready handshake carrying the match verdict and overflow flag.
// Standalone; no package needed.
interface gwm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

@@ design/gwm_step.sv @@
// Next-state logic for one word: pattern clear and load, bit-parallel text advance, end of text.
// Depends on gwm_pkg (types, constants, gwm_close).
module gwm_step (
    input  gwm_pkg::gwm_op_t   op,
    input  gwm_pkg::char_t     ch,
    input  gwm_pkg::gwm_state_t cur,
    input  gwm_pkg::char_t     store [gwm_pkg::MAX_PATTERN],
    output gwm_pkg::gwm_state_t nxt,
    output gwm_pkg::gwm_ctrl_t ctrl
);
    import gwm_pkg::*;

    pos_vec_t  seed_one;
    pos_vec_t  adv;
    star_vec_t star_app;
    logic      has_room;

    assign seed_one = POS_N'(1);
    assign has_room = (cur.length < LEN_W'(MAX_PATTERN));
    assign star_app = cur.star | (MAX_PATTERN'(ch == STAR_BYTE) << cur.length);

    // Advance every active position by one text byte; stars hold in place.
    always_comb
    begin
        adv = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (cur.active[i] && (LEN_W'(i) < cur.length))
            begin
                if (cur.star[i])
                    adv[i] = 1'b1;
                else if (store[i] == ANY_BYTE || store[i] == ch)
                    adv[i+1] = 1'b1;
            end
        end
    end

    always_comb
    begin
        nxt  = cur;
        ctrl = '0;
        ctrl.store_idx = cur.length[IDX_W-1:0];
        unique case (op)
            OP_CLEAR:
            begin
                nxt.length   = '0;
                nxt.star     = '0;
                nxt.overflow = 1'b0;
                nxt.active   = seed_one;
            end
            OP_APPEND:
            begin
                if (has_room)
                begin
                    ctrl.store_we = 1'b1;
                    nxt.length    = cur.length + LEN_W'(1);
                    nxt.star      = star_app;
                    nxt.active    = gwm_close(seed_one, star_app);
                end
                else
                begin
                    nxt.overflow = 1'b1;
                    nxt.active   = gwm_close(seed_one, cur.star);
                end
            end
            OP_TEXT:
            begin
                nxt.active = gwm_close(adv, cur.star);
            end
            OP_END:
            begin
                ctrl.emit     = 1'b1;
                ctrl.matched  = cur.active[cur.length] & ~cur.overflow;
                ctrl.overflow = cur.overflow;
                nxt.active    = gwm_close(seed_one, cur.star);
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

@@ design/glob_wildcard_matcher_core.sv @@
// Top level of the glob wildcard matcher: input register, state, result register.
// Depends on gwm_pkg, gwm_in_if, gwm_out_if and gwm_step.
//
//   channel      modport   moves                          when taken
//   ----------   -------   ----------------------------   --------------------
//   cmd_in       sink      opcode, char_value             valid && ready
//   result_out   source    matched, pattern_overflow      valid && ready
//
// One word per cycle is accepted unless an end of text word waits on a stalled
// result. A word is held in the input register, then the step logic (byte
// compares plus a log-depth star closure over all pattern positions) updates
// the state; an end of text word also loads the result register.
// Reset clears the pattern length, overflow flag and star mask and leaves only
// position zero active; pattern bytes are not reset and are read only below
// the length. A stalled result holds only end of text words; other words keep
// flowing past it.
module glob_wildcard_matcher_core (
    input  logic          clk,
    input  logic          rst_n,
    gwm_in_if.sink        cmd_in,
    gwm_out_if.source     result_out
);
    import gwm_pkg::*;

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    gwm_op_t    in_op_reg;
    char_t      in_ch_reg;

    // matcher state and pattern bytes
    gwm_state_t state_reg;
    gwm_state_t state_next;
    char_t      store_reg [MAX_PATTERN];

    // result register
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_matched_reg;
    logic       out_overflow_reg;

    gwm_ctrl_t  ctrl;
    logic       proc;
    logic       take;

    gwm_step u_step (
        .op    (in_op_reg),
        .ch    (in_ch_reg),
        .cur   (state_reg),
        .store (store_reg),
        .nxt   (state_next),
        .ctrl  (ctrl)
    );

    // Process the held word unless it would produce a result with nowhere to go.
    assign proc = in_valid_reg &&
                  ((in_op_reg != OP_END) || !out_valid_reg || result_out.ready);
    assign take = cmd_in.valid && cmd_in.ready;

    assign cmd_in.ready = !in_valid_reg || proc;

    assign result_out.valid            = out_valid_reg;
    assign result_out.matched          = out_matched_reg;
    assign result_out.pattern_overflow = out_overflow_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (proc)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (proc && ctrl.emit)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg.length <= '0;
            state_reg.star   <= '0;
            state_reg.active <= POS_N'(1);
            state_reg.overflow <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc)
                state_reg <= state_next;
        end
    end

    // Payload: hold the input word, write pattern bytes, load the result.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_op_reg <= gwm_op_t'(cmd_in.opcode);
            in_ch_reg <= cmd_in.char_value;
        end
        if (proc && ctrl.store_we)
            store_reg[ctrl.store_idx] <= in_ch_reg;
        if (proc && ctrl.emit)
        begin
            out_matched_reg  <= ctrl.matched;
            out_overflow_reg <= ctrl.overflow;
        end
    end

    // No active position lies beyond the pattern end.
    a_active_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.active >> (state_reg.length + LEN_W'(1))) == '0)
        else $error("active position beyond pattern end");

    // Star marks exist only for stored pattern bytes.
    a_star_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.star >> state_reg.length) == '0)
        else $error("star mark beyond pattern end");

    // Overflow can only be set with a full store.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.overflow |-> (state_reg.length == LEN_W'(MAX_PATTERN)))
        else $error("overflow flag with room left in the store");

    // A new result follows only from a processed end of text word.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc && (in_op_reg == OP_END)))
        else $error("result without end of text");

    // A matched result never carries the overflow flag.
    a_match_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_matched_reg && out_overflow_reg))
        else $error("match reported with overflow");

endmodule
